@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the serial frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/sfr_pkg.sv @@
// Types and constants of the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  // Frame counter and total frame length width
  localparam int POS_W = 9;

  // Frame layout: bytes 2..8 are kept
  localparam int CAP_FIRST = 2;
  localparam int CAP_DEPTH = 7;
  localparam int LEN_POS   = 3;
  localparam int FRAME_OVERHEAD = 8;

  // Header bytes
  localparam logic [7:0] HDR0 = 8'h55;
  localparam logic [7:0] HDR1 = 8'haa;

  // Frame kinds that carry a range reading
  localparam logic [7:0] ADDR_RANGE    = 8'h53;
  localparam logic [7:0] SUBCODE_RANGE = 8'h01;
  localparam logic [7:0] ADDR_SONAR    = 8'h60;
  localparam logic [7:0] SUBCODE_SONAR = 8'h00;

  // Length placeholders left after a frame ends
  localparam logic [POS_W-1:0] EXP_AFTER_DONE = 9'd6;
  localparam logic [POS_W-1:0] EXP_AFTER_DROP = 9'd5;

  // One completed frame, from the parser to the output register
  typedef struct packed {
    logic        valid;
    logic [7:0]  address;
    logic [7:0]  length;
    logic [15:0] reading;
    logic        updated;
  } sfr_result_t;

endpackage

@@ hw/rtl/sfr_parser.sv @@
// Frame parser: header search, byte counting, capture and reading update.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_parser #(
  parameter int BUFFER_LIMIT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data,
  output sfr_pkg::sfr_result_t res
);
  import sfr_pkg::*;

  localparam logic [POS_W-1:0] LIMIT = POS_W'(BUFFER_LIMIT);

  logic [7:0]       prev_byte, prev_byte_next;
  logic             in_frame, in_frame_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next, pos_inc;
  logic [POS_W-1:0] expected_len, expected_len_next, exp_cur;
  logic [7:0]       cap [CAP_DEPTH];
  logic [7:0]       cap_w [CAP_DEPTH];
  logic [7:0]       cap_next [CAP_DEPTH];
  logic [15:0]      held, held_next, new_reading;
  logic             hdr, done, drop, upd, cap_nonzero;

  // Frame bytes as they stand with the current byte written in
  always_comb begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      cap_w[i] = cap[i];
      if (byte_pos == POS_W'(CAP_FIRST + i)) begin
        cap_w[i] = data;
      end
    end
  end

  assign hdr     = !in_frame && (prev_byte == HDR0) && (data == HDR1);
  assign pos_inc = byte_pos + POS_W'(1);
  assign exp_cur = (byte_pos == POS_W'(LEN_POS)) ?
                   POS_W'(data) + POS_W'(FRAME_OVERHEAD) : expected_len;

  // Next state for one byte
  always_comb begin
    prev_byte_next    = prev_byte;
    in_frame_next     = in_frame;
    byte_pos_next     = byte_pos;
    expected_len_next = expected_len;
    cap_next          = cap;
    done              = 1'b0;
    drop              = 1'b0;
    upd               = 1'b0;
    new_reading       = held;
    if (fire) begin
      if (hdr) begin
        in_frame_next  = 1'b1;
        byte_pos_next  = POS_W'(CAP_FIRST);
        prev_byte_next = 8'h00;
      end else if (!in_frame) begin
        prev_byte_next = data;
      end else begin
        byte_pos_next     = pos_inc;
        expected_len_next = exp_cur;
        cap_next          = cap_w;
        done              = (pos_inc == exp_cur);
        drop              = (pos_inc >= LIMIT);
        // cap_w[0] is frame byte 2, cap_w[6] is frame byte 8
        if (done) begin
          if (cap_w[0] == ADDR_RANGE && cap_w[2] == SUBCODE_RANGE) begin
            upd         = 1'b1;
            new_reading = {cap_w[3], cap_w[4]};
          end else if (cap_w[0] == ADDR_SONAR && cap_w[3] == SUBCODE_SONAR) begin
            upd         = 1'b1;
            new_reading = {cap_w[5], cap_w[6]};
          end
        end
        if (done || drop) begin
          in_frame_next     = 1'b0;
          expected_len_next = drop ? EXP_AFTER_DROP : EXP_AFTER_DONE;
          for (int i = 0; i < CAP_DEPTH; i++) begin
            cap_next[i] = 8'h00;
          end
        end
      end
    end
    held_next = upd ? new_reading : held;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte    <= 8'h00;
      in_frame     <= 1'b0;
      byte_pos     <= '0;
      expected_len <= '0;
      held         <= 16'h0000;
      for (int i = 0; i < CAP_DEPTH; i++) begin
        cap[i] <= 8'h00;
      end
    end else begin
      prev_byte    <= prev_byte_next;
      in_frame     <= in_frame_next;
      byte_pos     <= byte_pos_next;
      expected_len <= expected_len_next;
      held         <= held_next;
      cap          <= cap_next;
    end
  end

  // Result of this byte
  always_comb begin
    res.valid   = done;
    res.address = cap_w[0];
    res.length  = cap_w[1];
    res.reading = held_next;
    res.updated = upd;
  end

  // Captured bytes are all zero outside a frame
  always_comb begin
    cap_nonzero = 1'b0;
    for (int i = 0; i < CAP_DEPTH; i++) begin
      cap_nonzero = cap_nonzero | (|cap[i]);
    end
  end

  `ASSERT_NEXT(a_frame_closes, clk, rst, done, !in_frame)
  `ASSERT_IMPL(a_pos_below_limit, clk, rst, in_frame, byte_pos < LIMIT)
  `ASSERT_IMPL(a_idle_cap_clear, clk, rst, !in_frame, !cap_nonzero)
  `ASSERT_IMPL(a_held_only_on_update, clk, rst, !$past(rst) && (held != $past(held)), $past(upd))

endmodule

@@ hw/rtl/serial_frame_receiver_range_extract.sv @@
// Top level of the serial frame receiver with range extraction.
`timescale 1ns / 1ps

// Serial frame receiver with range extraction.
// Input channel: one received byte (rx_byte) per transfer on in_valid/in_ready.
// Output channel: one transfer per completed frame on out_valid/out_ready,
//   carrying the frame address, parameter length, the held range reading
//   after the frame, and a flag set when that frame replaced the reading.
// Bytes outside a frame are scanned for the 0x55 0xAA header; frames that
//   reach BUFFER_LIMIT bytes without ending are dropped with no transfer.
// Result path: a frame's last byte passes through the input register, then the
//   parser into the output register, where the result is presented and can
//   transfer out at the following edge.
// Throughput: one byte per cycle while out_ready is high; each byte passes
//   through one stage of compares and a 9-bit counter add.
// Reset (rst, synchronous): clears the header search, frame counter, captured
//   bytes, held reading and the valid flags of both pipeline registers.
// Stall: when a result is held with out_ready low, the pipeline stops and
//   in_ready drops once the input register is occupied; nothing is lost.
module serial_frame_receiver_range_extract #(
  parameter int BUFFER_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_address,
  output logic [7:0]  param_length,
  output logic [15:0] range_reading,
  output logic        reading_updated
);
  import sfr_pkg::*;

  logic        in_q_valid;
  logic [7:0]  in_q_byte;
  logic        advance, fire;
  sfr_result_t res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign fire     = in_q_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= rx_byte;
    end
  end

  sfr_parser #(
    .BUFFER_LIMIT(BUFFER_LIMIT)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .data (in_q_byte),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      frame_address   <= res.address;
      param_length    <= res.length;
      range_reading   <= res.reading;
      reading_updated <= res.updated;
    end
  end

endmodule

@@ verif/serial_frame_receiver_range_extract_tb.sv @@
// Testbench for the serial frame receiver with range extraction.
`timescale 1ns / 1ps

module serial_frame_receiver_range_extract_tb;
  import sfr_pkg::*;

  localparam int FRAME_LIMIT = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;

  // One completed frame as seen on the output channel
  typedef struct packed {
    logic [7:0]  address;
    logic [7:0]  length;
    logic [15:0] reading;
    logic        updated;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_address;
  logic [7:0]  param_length;
  logic [15:0] range_reading;
  logic        reading_updated;

  // Mirror of the parser state
  logic [7:0]       last_idle_byte;
  logic             framing;
  logic [POS_W-1:0] frame_pos;
  logic [POS_W-1:0] frame_len;
  logic [7:0]       kept_bytes [CAP_DEPTH];
  logic [15:0]      range_held;

  frame_report_t reports_due [$];
  int error_count = 0;
  int rx_bytes_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int held_cycles = 0;

  serial_frame_receiver_range_extract #(
    .BUFFER_LIMIT(FRAME_LIMIT)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_address  (frame_address),
    .param_length   (param_length),
    .range_reading  (range_reading),
    .reading_updated(reading_updated)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && held_cycles < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_req) held_cycles <= 0;
    end
  end

  // Compare each output transfer against the oldest expected report
  always @(posedge clk) begin
    frame_report_t exp_rpt;
    if (!rst && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("unexpected frame report: address %0h length %0h", frame_address,
               param_length);
        error_count++;
      end else begin
        exp_rpt = reports_due.pop_front();
        if (frame_address !== exp_rpt.address) begin
          $error("frame_address: expected %0h, got %0h", exp_rpt.address, frame_address);
          error_count++;
        end
        if (param_length !== exp_rpt.length) begin
          $error("param_length: expected %0h, got %0h", exp_rpt.length, param_length);
          error_count++;
        end
        if (range_reading !== exp_rpt.reading) begin
          $error("range_reading: expected %0h, got %0h", exp_rpt.reading, range_reading);
          error_count++;
        end
        if (reading_updated !== exp_rpt.updated) begin
          $error("reading_updated: expected %0b, got %0b", exp_rpt.updated,
                 reading_updated);
          error_count++;
        end
      end
    end
  end

  function automatic void clear_kept_bytes();
    for (int i = 0; i < CAP_DEPTH; i++) kept_bytes[i] = 8'h00;
  endfunction

  function automatic void reset_parser_model();
    last_idle_byte = 8'h00;
    framing = 1'b0;
    frame_pos = '0;
    frame_len = '0;
    range_held = 16'h0000;
    clear_kept_bytes();
  endfunction

  // Advance the parser mirror by one received byte; queue a report on frame end.
  // kept_bytes[0] holds frame byte 2, kept_bytes[6] frame byte 8.
  function automatic void parse_rx_byte(input logic [7:0] b);
    frame_report_t rpt;
    if (!framing && last_idle_byte == HDR0 && b == HDR1) begin
      framing = 1'b1;
      frame_pos = POS_W'(CAP_FIRST);
      last_idle_byte = 8'h00;
      return;
    end
    if (!framing) begin
      last_idle_byte = b;
      return;
    end
    if (frame_pos >= CAP_FIRST && frame_pos < CAP_FIRST + CAP_DEPTH)
      kept_bytes[frame_pos - CAP_FIRST] = b;
    if (frame_pos == LEN_POS) frame_len = {1'b0, b} + POS_W'(FRAME_OVERHEAD);
    frame_pos = frame_pos + 1'b1;
    if (frame_pos == frame_len) begin
      rpt.updated = 1'b0;
      if (kept_bytes[0] == ADDR_RANGE && kept_bytes[2] == SUBCODE_RANGE) begin
        range_held = {kept_bytes[3], kept_bytes[4]};
        rpt.updated = 1'b1;
      end else if (kept_bytes[0] == ADDR_SONAR && kept_bytes[3] == SUBCODE_SONAR) begin
        range_held = {kept_bytes[5], kept_bytes[6]};
        rpt.updated = 1'b1;
      end
      rpt.address = kept_bytes[0];
      rpt.length = kept_bytes[1];
      rpt.reading = range_held;
      reports_due.push_back(rpt);
      clear_kept_bytes();
      frame_len = EXP_AFTER_DONE;
      framing = 1'b0;
    end
    // Oversized frame is dropped silently
    if (frame_pos >= FRAME_LIMIT) begin
      clear_kept_bytes();
      frame_len = EXP_AFTER_DROP;
      framing = 1'b0;
    end
  endfunction

  // Offer one byte, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b);
    rx_bytes_sent++;
  endtask

  // Header, address, length, then frame bytes 4 onward; long frames are cut
  // shortly past the buffer limit since the rest only lands outside a frame
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len,
                            input logic [7:0] b4, input logic [7:0] b5,
                            input logic [7:0] b6, input logic [7:0] b7,
                            input logic [7:0] b8);
    int total;
    logic [7:0] b;
    total = int'(len) + FRAME_OVERHEAD;
    if (total > FRAME_LIMIT + 2) total = FRAME_LIMIT + 2;
    send_rx_byte(HDR0);
    send_rx_byte(HDR1);
    send_rx_byte(addr);
    send_rx_byte(len);
    for (int i = 4; i < total; i++) begin
      case (i)
        4: b = b4;
        5: b = b5;
        6: b = b6;
        7: b = b7;
        8: b = b8;
        default: b = 8'($urandom_range(255));
      endcase
      send_rx_byte(b);
    end
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  // Header only found as an adjacent pair of bytes
  task automatic test_header_search();
    send_rx_byte(8'h00);
    send_rx_byte(8'hff);
    send_rx_byte(HDR0);
    send_rx_byte(8'h13);
    send_rx_byte(HDR1);
    send_rx_byte(HDR0);
    send_frame(8'h21, 8'd0, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
  endtask

  // Both reading kinds, their near misses, and address extremes
  task automatic test_reading_frames();
    send_frame(ADDR_RANGE, 8'd1, SUBCODE_RANGE, 8'hff, 8'hff, rnd_byte(), rnd_byte());
    send_frame(ADDR_SONAR, 8'd2, 8'h37, SUBCODE_SONAR, 8'h11, 8'h00, 8'h00);
    send_frame(ADDR_RANGE, 8'd0, 8'h02, 8'h12, 8'h34, rnd_byte(), rnd_byte());
    send_frame(ADDR_SONAR, 8'd1, 8'h00, 8'h01, 8'h56, 8'h78, 8'h9a);
    send_frame(8'hff, 8'd0, SUBCODE_RANGE, SUBCODE_SONAR, 8'hff, 8'hff, 8'hff);
    send_frame(8'h00, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(ADDR_RANGE, 8'd3, SUBCODE_RANGE, 8'ha5, 8'h5a, rnd_byte(), rnd_byte());
  endtask

  // Length byte 0: frame byte 8 never arrives and reads as zero
  task automatic test_short_frame();
    send_frame(ADDR_SONAR, 8'd0, rnd_byte(), SUBCODE_SONAR, rnd_byte(), 8'hc3, 8'h77);
  endtask

  // Header bytes inside a frame are plain data
  task automatic test_header_in_payload();
    send_frame(8'h21, 8'd4, HDR0, HDR1, HDR0, HDR1, 8'h00);
    send_frame(ADDR_RANGE, 8'd2, SUBCODE_RANGE, HDR0, HDR1, rnd_byte(), rnd_byte());
  endtask

  // Frame ending right at the limit is reported; longer ones are dropped
  task automatic test_buffer_limit();
    send_frame(8'h44, 8'd56, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
    send_frame(ADDR_RANGE, 8'd57, SUBCODE_RANGE, 8'hde, 8'had, rnd_byte(), rnd_byte());
    send_frame(ADDR_SONAR, 8'd255, 8'h00, SUBCODE_SONAR, 8'h00, 8'hbe, 8'hef);
    send_frame(8'h5e, 8'd0, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
  endtask

  // Receiver holds off while short frames keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    repeat (6) begin
      send_frame(ADDR_RANGE, 8'd0, SUBCODE_RANGE, rnd_byte(), rnd_byte(), rnd_byte(),
                 rnd_byte());
    end
    hold_req <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some noise and broken headers
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int nbytes);
    int first;
    int roll;
    logic [7:0] addr;
    logic [7:0] len;
    logic [7:0] b4;
    logic [7:0] b5;
    first = rx_bytes_sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (rx_bytes_sent - first < nbytes) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        repeat ($urandom_range(1, 4)) send_rx_byte(rnd_byte());
      end else if (roll < 20) begin
        send_rx_byte(HDR0);
        send_rx_byte(rnd_byte());
      end
      roll = $urandom_range(99);
      if (roll < 40) addr = ADDR_RANGE;
      else if (roll < 70) addr = ADDR_SONAR;
      else addr = rnd_byte();
      roll = $urandom_range(99);
      if (roll < 70) len = 8'($urandom_range(0, 4));
      else if (roll < 93) len = 8'($urandom_range(5, 20));
      else len = 8'($urandom_range(21, 255));
      b4 = ($urandom_range(99) < 75) ? SUBCODE_RANGE : rnd_byte();
      b5 = ($urandom_range(99) < 75) ? SUBCODE_SONAR : rnd_byte();
      send_frame(addr, len, b4, b5, rnd_byte(), rnd_byte(), rnd_byte());
    end
  endtask

  initial begin
    reset_parser_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_header_search();
    test_reading_frames();
    test_short_frame();
    test_header_in_payload();
    test_buffer_limit();
    test_backpressure();
    test_random_traffic(0, 0, 18);
    test_random_traffic(46, 0, 18);
    test_random_traffic(0, 46, 18);
    test_random_traffic(35, 35, 18);
    in_valid <= 1'b0;

    // Drain outstanding reports, then let the pipeline settle
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_parser.sv
hw/rtl/serial_frame_receiver_range_extract.sv
verif/serial_frame_receiver_range_extract_tb.sv
